FILE: rtl/cwd_pkg.sv
// Package for the CRC-8 checked word deframer.
// Result types, status and register codes, CRC and float-sanitize functions.
// No dependencies.
package cwd_pkg;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_CRC = 2'd1;
  localparam logic [1:0] ST_LEN = 2'd2;

  // configuration register indexes
  localparam logic CFG_CRC_START  = 1'b0;
  localparam logic CFG_FLOAT_MODE = 1'b1;

  localparam logic [7:0]  CRC_START_RST = 8'hFF;
  localparam logic [31:0] EXP_MASK      = 32'h7F80_0000;
  localparam logic [31:0] SIGN_EXP_MASK = 32'hFF80_0000;

  // CRC-8 poly 0x31, one nibble per lookup
  localparam logic [7:0] NIB_TAB [16] = '{
    8'h00, 8'h31, 8'h62, 8'h53, 8'hc4, 8'hf5, 8'ha6, 8'h97,
    8'hb9, 8'h88, 8'hdb, 8'hea, 8'h7d, 8'h4c, 8'h1f, 8'h2e
  };

  // queued result beat: san marks a float pattern still to be sanitized
  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  status;
    logic        done;
    logic        san;
  } res_t;

  function automatic logic [7:0] crc_byte(logic [7:0] c, logic [7:0] b);
    logic [7:0] x;
    x = {c[3:0], 4'h0} ^ NIB_TAB[c[7:4] ^ b[7:4]];
    x = {x[3:0], 4'h0} ^ NIB_TAB[x[7:4] ^ b[3:0]];
    return x;
  endfunction

  function automatic logic [31:0] sanitize(logic [31:0] v);
    logic [31:0] r;
    if ((v & EXP_MASK) == EXP_MASK) begin
      r = '0;
    end else if ((v & EXP_MASK) == '0) begin
      r = v & SIGN_EXP_MASK;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/cwd_in_if.sv
// Input channel of the deframer: one received byte per beat.
// Standalone, no dependencies.
interface cwd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_first;
  logic       frame_last;

  modport source (output valid, rx_byte, frame_first, frame_last, input ready);
  modport sink   (input valid, rx_byte, frame_first, frame_last, output ready);
endinterface

FILE: rtl/cwd_out_if.sv
// Result channel of the deframer: one word, float or error per beat.
// Standalone, no dependencies.
interface cwd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_value;
  logic [1:0]  status;
  logic        frame_done;

  modport source (output valid, data_value, status, frame_done, input ready);
  modport sink   (input valid, data_value, status, frame_done, output ready);
endinterface

FILE: rtl/cwd_front.sv
// Front end: config registers, tuple framing, CRC check, float pairing.
// Depends on cwd_pkg and cwd_in_if.
module cwd_front (
  input  logic          clk,
  input  logic          rst_n,
  cwd_in_if.sink        in_ch,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_wdata,
  input  logic          q_full,
  output logic          push,
  output cwd_pkg::res_t push_res
);
  import cwd_pkg::*;

  logic [7:0]  crc_start_r;
  logic        float_mode_r;
  logic [1:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  b0_r, b0_nxt;
  logic [7:0]  b1_r, b1_nxt;
  logic [15:0] upper_r, upper_nxt;
  logic        half_r, half_nxt;
  logic        failed_r, failed_nxt;

  logic        acc;
  logic [1:0]  pos;
  logic        half, failed, emit;
  logic [1:0]  st;
  logic [31:0] val;
  logic        san;
  logic [15:0] word;
  logic [7:0]  b;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign word        = {b0_r, b1_r};

  always_comb begin
    pos        = in_ch.frame_first ? 2'd0 : pos_r;
    half       = in_ch.frame_first ? 1'b0 : half_r;
    failed     = in_ch.frame_first ? 1'b0 : failed_r;
    pos_nxt    = pos;
    half_nxt   = half;
    failed_nxt = failed;
    crc_nxt    = crc_r;
    b0_nxt     = b0_r;
    b1_nxt     = b1_r;
    upper_nxt  = upper_r;
    emit       = 1'b0;
    st         = ST_OK;
    val        = '0;
    san        = 1'b0;
    case (pos)
      2'd0: begin
        crc_nxt = crc_byte(crc_start_r, b);
        b0_nxt  = b;
        pos_nxt = 2'd1;
      end
      2'd1: begin
        crc_nxt = crc_byte(crc_r, b);
        b1_nxt  = b;
        pos_nxt = 2'd2;
      end
      default: begin
        pos_nxt = 2'd0;
        if (crc_r != b) begin
          emit = 1'b1;
          st   = ST_CRC;
        end else if (!float_mode_r) begin
          emit = 1'b1;
          val  = {16'h0000, word};
        end else if (!half) begin
          upper_nxt = word;
          half_nxt  = 1'b1;
        end else begin
          half_nxt = 1'b0;
          emit     = 1'b1;
          val      = {upper_r, word};
          san      = 1'b1;
        end
      end
    endcase
    if (in_ch.frame_last && !emit && (pos_nxt != 2'd0 || (float_mode_r && half_nxt))) begin
      emit = 1'b1;
      st   = ST_LEN;
    end
    if (failed) begin
      emit = 1'b0;
    end
    if (emit && st != ST_OK) begin
      failed_nxt = 1'b1;
    end
    if (in_ch.frame_last) begin
      pos_nxt    = 2'd0;
      half_nxt   = 1'b0;
      failed_nxt = 1'b0;
    end
  end

  assign push            = acc && emit;
  assign push_res.data   = (st != ST_OK) ? 32'h0 : val;
  assign push_res.status = st;
  assign push_res.done   = in_ch.frame_last;
  assign push_res.san    = san && (st == ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_start_r  <= CRC_START_RST;
      float_mode_r <= 1'b0;
      pos_r        <= 2'd0;
      half_r       <= 1'b0;
      failed_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CRC_START:  crc_start_r  <= cfg_wdata;
          CFG_FLOAT_MODE: float_mode_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (acc) begin
        pos_r    <= pos_nxt;
        half_r   <= half_nxt;
        failed_r <= failed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r    <= '0;
      b1_r    <= '0;
      upper_r <= '0;
    end else if (acc) begin
      b0_r    <= b0_nxt;
      b1_r    <= b1_nxt;
      upper_r <= upper_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      crc_r <= crc_nxt;
    end
  end

endmodule

FILE: rtl/cwd_fifo.sv
// Short result queue between front and back ends.
// Depends on cwd_pkg.
module cwd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cwd_pkg::res_t push_res,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output cwd_pkg::res_t head
);
  import cwd_pkg::*;

  res_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wp_r, rp_r;
  logic [FIFO_CW-1:0]   cnt_r;

  assign full  = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  function automatic logic [FIFO_AW-1:0] ptr_inc(logic [FIFO_AW-1:0] p);
    return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= ptr_inc(wp_r);
      end
      if (pop) begin
        rp_r <= ptr_inc(rp_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_res;
    end
  end

endmodule

FILE: rtl/cwd_back.sv
// Back end: drains the queue into the output register, sanitizing floats.
// Depends on cwd_pkg and cwd_out_if.
module cwd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  cwd_pkg::res_t head,
  output logic          pop,
  cwd_out_if.source     out_ch
);
  import cwd_pkg::*;

  logic        valid_r;
  logic [31:0] data_r;
  logic [1:0]  status_r;
  logic        done_r;

  assign pop = !q_empty && (!valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r   <= head.san ? sanitize(head.data) : head.data;
      status_r <= head.status;
      done_r   <= head.done;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.data_value = data_r;
  assign out_ch.status     = status_r;
  assign out_ch.frame_done = done_r;

endmodule

FILE: rtl/crc8_checked_word_deframer_top.sv
// CRC-8 checked word deframer. Takes one response byte per beat (any rate up to
// one per cycle); bytes group into tuples of two data bytes and a CRC-8 byte
// (poly 0x31, MSB first, start value from register 0, no final xor). Word mode
// gives each good tuple as a big-endian 16-bit value in the low half of
// data_value; float mode (register 1) pairs two good tuples into a float with
// NaN/Inf forced to 0 and zero/denormal reduced to its sign. A CRC mismatch
// (status 1) or a frame ending mid-tuple or mid-pair (status 2) gives one error
// beat with data 0, and the rest of the frame is dropped. Throughput is one
// byte per cycle while the queue has room; the front end decides on a taken
// byte in the same cycle and writes its result to the queue, from which the
// output register loads it. A two-entry queue between the front end and the
// output register lets input keep flowing while a result waits; in_ready
// falls only when that queue is full. Config writes are meant for idle time.
// Depends on cwd_pkg, cwd_in_if, cwd_out_if, cwd_front, cwd_fifo, cwd_back.
module crc8_checked_word_deframer_top (
  input  logic       clk,
  input  logic       rst_n,
  cwd_in_if.sink     in_ch,
  cwd_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);
  import cwd_pkg::*;

  logic push, pop, q_full, q_empty;
  res_t push_res, head;

  // framing, CRC and pairing state; decides which bytes make a result
  cwd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .q_full   (q_full),
    .push     (push),
    .push_res (push_res)
  );

  // decouples the byte side from output back-pressure
  cwd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_res(push_res),
    .pop     (pop),
    .full    (q_full),
    .empty   (q_empty),
    .head    (head)
  );

  // float cleanup and the registered result beat
  cwd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_empty(q_empty),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

FILE: rtl/cwd_checker.sv
// Port-level checks on the deframer result channel, bound to the top level.
// Depends on cwd_pkg and crc8_checked_word_deframer_top.
module cwd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_data,
  input logic [1:0]  out_status
);
  import cwd_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data) && $stable(out_status))
    else $error("result payload changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_data == 32'h0)
    else $error("error beat carries nonzero data");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_CRC || out_status == ST_LEN))
    else $error("undefined status code");

endmodule

bind crc8_checked_word_deframer_top cwd_checker u_cwd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data_value),
  .out_status(out_ch.status)
);

FILE: bench/crc8_checked_word_deframer_top_tb.sv
// Self-checking bench for crc8_checked_word_deframer_top: CRC-8 tuple deframing
// in word and float modes, checked beat by beat against an in-bench predictor.
// Depends on cwd_pkg, cwd_in_if, cwd_out_if and the RTL of the block.
`timescale 1ns / 100ps

import cwd_pkg::*;

localparam logic [7:0] CRC8_POLY = 8'h31;

// One CRC-8 byte update, MSB first, bit at a time.
function automatic logic [7:0] crc8_step(logic [7:0] c, logic [7:0] b);
  logic [7:0] x;
  x = c ^ b;
  for (int i = 0; i < 8; i++) x = x[7] ? ((x << 1) ^ CRC8_POLY) : (x << 1);
  return x;
endfunction

function automatic logic [7:0] tuple_crc(logic [7:0] start, logic [15:0] w);
  return crc8_step(crc8_step(start, w[15:8]), w[7:0]);
endfunction

typedef struct {
  logic [31:0] value;
  logic [1:0]  status;
  logic        done;
} result_beat_t;

// Predicts the result beats of the deframer and checks the ones it emits.
class deframe_scoreboard;
  logic [7:0]   crc_start;
  bit           float_mode;
  logic [1:0]   pos;
  logic [7:0]   crc, hi_byte, lo_byte;
  logic [15:0]  upper;
  bit           half, failed;
  result_beat_t expected_beats[$];
  int           failures, reports, checked, error_beats;

  function new();
    crc_start = CRC_START_RST;
    float_mode = 1'b0;
    hi_byte = '0;
    lo_byte = '0;
    upper = '0;
    crc = CRC_START_RST;
    failures = 0;
    reports = 0;
    checked = 0;
    error_beats = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    pos = 2'd0;
    half = 1'b0;
    failed = 1'b0;
  endfunction

  function void write_reg(logic idx, logic [7:0] v);
    if (idx == CFG_CRC_START) crc_start = v;
    else float_mode = v[0];
  endfunction

  // NaN/Inf -> 0, zero/denormal -> sign only
  function logic [31:0] clean_float(logic [31:0] f);
    if (&f[30:23]) return 32'h0;
    if (f[30:23] == 8'h00) return {f[31], 31'h0};
    return f;
  endfunction

  function void note_byte(logic [7:0] b, bit sof, bit eof);
    bit          emit;
    logic [31:0] val;
    logic [1:0]  st;
    emit = 1'b0;
    val = '0;
    st = ST_OK;
    if (sof) clear_frame();
    case (pos)
      2'd0: begin
        crc = crc8_step(crc_start, b);
        hi_byte = b;
        pos = 2'd1;
      end
      2'd1: begin
        crc = crc8_step(crc, b);
        lo_byte = b;
        pos = 2'd2;
      end
      default: begin
        pos = 2'd0;
        if (crc != b) begin
          emit = 1'b1;
          st = ST_CRC;
        end else if (!float_mode) begin
          emit = 1'b1;
          val = {16'h0, hi_byte, lo_byte};
        end else if (!half) begin
          upper = {hi_byte, lo_byte};
          half = 1'b1;
        end else begin
          half = 1'b0;
          emit = 1'b1;
          val = clean_float({upper, hi_byte, lo_byte});
        end
      end
    endcase
    if (eof && !emit && (pos != 2'd0 || (float_mode && half))) begin
      emit = 1'b1;
      st = ST_LEN;
    end
    if (failed) emit = 1'b0;
    if (emit && st != ST_OK) failed = 1'b1;
    if (eof) clear_frame();
    if (emit) expected_beats.push_back('{(st == ST_OK) ? val : 32'h0, st, eof});
  endfunction

  function void check_beat(logic [31:0] v, logic [1:0] st, logic done);
    result_beat_t e;
    checked++;
    if (st != ST_OK) error_beats++;
    if (expected_beats.size() == 0) begin
      failures++;
      if (reports < 10) begin
        reports++;
        $display("unexpected result beat: data %h status %0d done %0d", v, st, done);
      end
      return;
    end
    e = expected_beats.pop_front();
    if (v !== e.value || st !== e.status || done !== e.done) begin
      failures++;
      if (reports < 10) begin
        reports++;
        $display("mismatch: expected data %h status %0d done %0d, got data %h status %0d done %0d",
                 e.value, e.status, e.done, v, st, done);
      end
    end
  endfunction

  function int pending();
    return expected_beats.size();
  endfunction
endclass

module crc8_checked_word_deframer_top_tb;

  localparam int LONG_HOLD   = 120;   // cycles of receiver hold-off under pressure
  localparam int SEG_ITEMS   = 155;   // bytes per random segment
  localparam int N_SEGMENTS  = 6;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_wdata;

  cwd_in_if  in_ch();
  cwd_out_if out_ch();

  crc8_checked_word_deframer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  deframe_scoreboard sb;

  // Settings the stimulus works under; mirrors what was written to the block.
  logic [7:0] cur_crc_start = CRC_START_RST;
  bit         cur_float     = 1'b0;

  // Idle rates, in percent of cycles, for each side.
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;

  // Long hold requests: the stimulus bumps holds_asked, the receiver serves it.
  int holds_asked = 0;
  int items_sent  = 0;

  always #10 clk = ~clk;

  // Run guard: far beyond the slowest legal run (about 1k bytes, heavy stalls).
  initial begin
    #2_000_000;
    $display("crc8_checked_word_deframer_top test failed");
    $finish;
  end

  // Receiver: random backpressure plus the long hold-off, and the result
  // check on every accepted beat. ready and valid are sampled as they stood
  // at the edge, since the block's registers update after this process reads.
  initial begin
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else begin
        if (out_ch.valid && out_ch.ready)
          sb.check_beat(out_ch.data_value, out_ch.status, out_ch.frame_done);
        if (holds_served != holds_asked) begin
          holds_served = holds_asked;
          hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
      end
    end
  end

  // Offer one byte and hold it until the beat is taken. Nothing is driven
  // after the taking edge: the caller's next drive lands in that same step,
  // so valid never gets two updates in one step.
  task automatic send_byte(logic [7:0] b, bit sof, bit eof);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.rx_byte     <= b;
    in_ch.frame_first <= sof;
    in_ch.frame_last  <= eof;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(b, sof, eof);
    items_sent++;
  endtask

  task automatic send_tuple(logic [15:0] w, bit sof, bit eof, bit corrupt);
    logic [7:0] c;
    c = tuple_crc(cur_crc_start, w);
    if (corrupt) c = c ^ 8'($urandom_range(1, 255));
    send_byte(w[15:8], sof, 1'b0);
    send_byte(w[7:0], 1'b0, 1'b0);
    send_byte(c, 1'b0, eof);
  endtask

  // Register write only once the block has drained: all expected beats in,
  // then a few cycles for bytes still in the front end that give no result.
  task automatic set_config(logic idx, logic [7:0] v);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, v);
    if (idx == CFG_CRC_START) cur_crc_start = v;
    else cur_float = v[0];
  endtask

  // Data word for a tuple. Float upper halves lean on all-ones and zero
  // exponents; other words now and then are all zeros or all ones.
  function automatic logic [15:0] make_word(bit float_upper);
    logic [15:0] w;
    w = 16'($urandom);
    if (float_upper) begin
      case ($urandom_range(3))
        0:       w[14:7] = 8'hFF;
        1:       w[14:7] = 8'h00;
        default: ;
      endcase
    end else if ($urandom_range(7) == 0) begin
      w = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    end
    return w;
  endfunction

  // Mostly well-formed frames with random words; some with a bad CRC, some
  // cut short (mid-tuple or, in float mode, mid-pair), a few pure noise.
  task automatic send_random_frame();
    logic [7:0]  frame_q[$];
    logic [15:0] w;
    logic [7:0]  c;
    int          kind, n_tup, bad_at, cut;
    bit          lead;
    kind = $urandom_range(99);
    lead = ($urandom_range(9) != 0);
    if (kind >= 94) begin
      repeat ($urandom_range(1, 8))
        send_byte(8'($urandom), $urandom_range(3) == 0, $urandom_range(4) == 0);
      return;
    end
    n_tup  = cur_float ? 2 * $urandom_range(1, 3) : $urandom_range(1, 5);
    bad_at = (kind >= 70 && kind < 85) ? $urandom_range(0, n_tup - 1) : -1;
    cut    = (kind >= 85) ? $urandom_range(1, cur_float ? 3 : 2) : 0;
    for (int t = 0; t < n_tup; t++) begin
      w = make_word(cur_float && (t % 2 == 0));
      c = tuple_crc(cur_crc_start, w);
      if (t == bad_at) c = c ^ 8'($urandom_range(1, 255));
      frame_q.push_back(w[15:8]);
      frame_q.push_back(w[7:0]);
      frame_q.push_back(c);
    end
    repeat (cut) void'(frame_q.pop_back());
    foreach (frame_q[i]) send_byte(frame_q[i], lead && i == 0, i == frame_q.size() - 1);
  endtask

  initial begin
    sb = new();
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.rx_byte     <= '0;
    in_ch.frame_first <= 1'b0;
    in_ch.frame_last  <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_CRC_START;
    cfg_wdata         <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, word mode at reset settings (start 0xFF) ---
    // all-zero and all-one words, frame_done on the last
    send_tuple(16'h0000, 1'b1, 1'b0, 1'b0);
    send_tuple(16'hFFFF, 1'b0, 1'b1, 1'b0);
    // bad CRC first: one error beat, then the rest of the frame is dropped
    send_tuple(16'hBEEF, 1'b1, 1'b0, 1'b1);
    send_tuple(16'h1234, 1'b0, 1'b1, 1'b0);
    // frame ends mid-tuple; no frame_first, the previous last reopened framing
    send_byte(8'hA5, 1'b0, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b1);
    // single-byte frame
    send_byte(8'h00, 1'b1, 1'b1);

    // --- directed, float mode ---
    set_config(CFG_FLOAT_MODE, 8'h01);
    // all-ones exponent forced to zero, then a lone upper half at frame end
    send_tuple(16'hFF80, 1'b1, 1'b0, 1'b0);
    send_tuple(16'h0001, 1'b0, 1'b0, 1'b0);
    send_tuple(16'h8000, 1'b0, 1'b1, 1'b0);
    // good upper half gives nothing; leaving float mode mid-frame turns the
    // next tuple into a plain word and the waiting half is not an error
    send_tuple(16'h3F80, 1'b1, 1'b0, 1'b0);
    set_config(CFG_FLOAT_MODE, 8'h00);
    send_tuple(16'h1234, 1'b0, 1'b1, 1'b0);

    // --- random segments: idle pattern and register settings per segment ---
    for (int seg = 0; seg < N_SEGMENTS; seg++) begin
      case (seg)
        0: set_config(CFG_CRC_START, 8'h00);
        1: set_config(CFG_CRC_START, 8'($urandom));
        2: set_config(CFG_CRC_START, 8'hFF);
        3: set_config(CFG_CRC_START, 8'($urandom));
        4: set_config(CFG_CRC_START, 8'h00);
        default: set_config(CFG_CRC_START, 8'hFF);
      endcase
      set_config(CFG_FLOAT_MODE, {7'h0, seg[0]});
      // sender 36 / receiver 50, then swapped, then no idling
      if (seg < 2) begin
        src_idle_pct  = 36;
        sink_idle_pct = 50;
      end else if (seg < 4) begin
        src_idle_pct  = 50;
        sink_idle_pct = 36;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        // receiver stalls long while bytes keep coming: queue fills, input stalls
        holds_asked++;
      end
      while (items_sent < 30 + (seg + 1) * SEG_ITEMS) send_random_frame();
    end

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes in word and float modes, CRC start 00/FF/random, with stalls;",
             items_sent);
    $display("checked %0d result beats, %0d of them error beats, %0d failures.",
             sb.checked, sb.error_beats, sb.failures + sb.pending());
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("crc8_checked_word_deframer_top test passed");
    end else begin
      $display("crc8_checked_word_deframer_top test failed");
    end
    $finish;
  end

endmodule
